// File: rtl/core/sbs_pkg.sv
package sbs_pkg;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_RUN  = 2'd1,
    KIND_STOP = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_RETRACTED  = 2'd0,
    PH_EXTENDING  = 2'd1,
    PH_RETRACTING = 2'd2,
    PH_UNUSED     = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    CFG_EXTEND_MS      = 2'd0,
    CFG_RETRACT_MS     = 2'd1,
    CFG_SHOTS_PER_PULL = 2'd2,
    CFG_BURST_MODE     = 2'd3
  } cfg_idx_e;

  localparam logic [7:0] ExtendMsRst     = 8'd30;
  localparam logic [7:0] RetractMsRst    = 8'd40;
  localparam logic [7:0] ShotsPerPullRst = 8'd1;
  localparam logic [7:0] ShotMax         = 8'd255;

  typedef struct packed {
    logic [7:0] extend_ms;
    logic [7:0] retract_ms;
    logic [7:0] shots_per_pull;
    logic       burst_mode;
  } cfg_t;

  typedef struct packed {
    logic       run;
    logic       last_run;
    phase_e     phase;
    logic [7:0] remaining_ms;
    logic [7:0] shot_count;
  } state_t;

endpackage

// File: rtl/core/sbs_step.sv
module sbs_step (
  input  sbs_pkg::cfg_t   cfg_i,
  input  sbs_pkg::state_t state_i,
  input  sbs_pkg::kind_e  kind_i,
  input  logic            trigger_pressed_i,
  output sbs_pkg::state_t state_o,
  output logic            wheel_slow_o
);
  import sbs_pkg::*;

  always_comb begin
    state_t s;
    s = state_i;
    wheel_slow_o = 1'b0;
    case (kind_i)
      KIND_TICK: begin
        if (s.remaining_ms != 8'd0) begin
          s.remaining_ms = s.remaining_ms - 8'd1;
        end
        if (s.run) begin
          // fresh burst: behaves like a run request plus a shot start
          if (!s.last_run && s.phase == PH_RETRACTED) begin
            s.last_run     = 1'b1;
            s.shot_count   = 8'd0;
            s.phase        = PH_EXTENDING;
            s.remaining_ms = cfg_i.extend_ms;
          end
          if (s.remaining_ms == 8'd0) begin
            if (s.phase == PH_EXTENDING) begin
              if (s.shot_count != ShotMax) begin
                s.shot_count = s.shot_count + 8'd1;
              end
              s.phase        = PH_RETRACTING;
              s.remaining_ms = cfg_i.retract_ms;
            end else if (s.phase == PH_RETRACTING) begin
              if (s.shot_count >= cfg_i.shots_per_pull ||
                  (!trigger_pressed_i && !cfg_i.burst_mode)) begin
                s.last_run   = s.run;
                s.run        = 1'b0;
                wheel_slow_o = 1'b1;
              end else begin
                s.phase        = PH_EXTENDING;
                s.remaining_ms = cfg_i.extend_ms;
              end
            end
          end
        end else if (s.remaining_ms == 8'd0 && s.phase == PH_RETRACTING) begin
          s.phase = PH_RETRACTED;
        end
      end
      KIND_RUN: begin
        s.last_run   = s.run;
        s.run        = 1'b1;
        s.shot_count = 8'd0;
      end
      KIND_STOP: begin
        s.last_run = s.run;
        s.run      = 1'b0;
      end
      default: begin
      end
    endcase
    state_o = s;
  end

endmodule

// File: rtl/core/solenoid_burst_sequencer.sv
// channel | dir | handshake                | payload
// input   | in  | in_valid_i / in_stall_o  | kind_i, trigger_pressed_i
// result  | out | out_valid_o / out_stall_i| drive_on_o, phase_o, running_o,
//         |     |                          | shots_fired_o, wheel_slow_o
// config  | in  | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
// one beat per cycle sustained while out_stall_i is low; a beat reaches the result ports through
// (input register, then sequencer state and result register updated together)
// reset clears state, handshake valids and config to its defaults
// an output stall backs up through the input register to in_stall_o
module solenoid_burst_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] kind_i,
  input  logic       trigger_pressed_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       drive_on_o,
  output logic [1:0] phase_o,
  output logic       running_o,
  output logic [7:0] shots_fired_o,
  output logic       wheel_slow_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);
  import sbs_pkg::*;

  cfg_t   cfg_q;
  state_t state_q, state_d;
  logic   in_valid_q;
  kind_e  kind_q;
  logic   trig_q;
  logic   out_valid_q;
  logic   slow_d, slow_q;
  logic   advance;
  logic   in_accept;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.extend_ms      <= ExtendMsRst;
      cfg_q.retract_ms     <= RetractMsRst;
      cfg_q.shots_per_pull <= ShotsPerPullRst;
      cfg_q.burst_mode     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_EXTEND_MS:      cfg_q.extend_ms      <= cfg_wdata_i;
        CFG_RETRACT_MS:     cfg_q.retract_ms     <= cfg_wdata_i;
        CFG_SHOTS_PER_PULL: cfg_q.shots_per_pull <= cfg_wdata_i;
        CFG_BURST_MODE:     cfg_q.burst_mode     <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q <= kind_e'(kind_i);
      trig_q <= trigger_pressed_i;
    end
  end

  sbs_step u_step (
    .cfg_i             (cfg_q),
    .state_i           (state_q),
    .kind_i            (kind_q),
    .trigger_pressed_i (trig_q),
    .state_o           (state_d),
    .wheel_slow_o      (slow_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.run          <= 1'b0;
      state_q.last_run     <= 1'b0;
      state_q.phase        <= PH_RETRACTED;
      state_q.remaining_ms <= 8'd0;
      state_q.shot_count   <= 8'd0;
      out_valid_q          <= 1'b0;
    end else begin
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      slow_q <= slow_d;
    end
  end

  // result fields come straight from the state written with the beat
  assign out_valid_o   = out_valid_q;
  assign drive_on_o    = (state_q.phase == PH_EXTENDING);
  assign phase_o       = state_q.phase;
  assign running_o     = state_q.run;
  assign shots_fired_o = state_q.shot_count;
  assign wheel_slow_o  = slow_q;

endmodule

// File: rtl/core/sbs_checker.sv
module sbs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       drive_on_o,
  input logic [1:0] phase_o,
  input logic       running_o,
  input logic [7:0] shots_fired_o,
  input logic       wheel_slow_o
);
  import sbs_pkg::*;

  // coil drive follows the phase
  a_drive_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_on_o == (phase_o == PH_EXTENDING)))
    else $error("drive_on does not match phase");

  // burst end leaves the block stopped mid retraction
  a_slow_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && wheel_slow_o) |-> (!running_o && phase_o == PH_RETRACTING))
    else $error("wheel_slow without stop in retraction");

  // input side only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with free result register");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(phase_o) && $stable(shots_fired_o) &&
       $stable(running_o) && $stable(wheel_slow_o)))
    else $error("stalled result changed");

endmodule

bind solenoid_burst_sequencer sbs_checker u_sbs_checker (.*);
